// ===== rtl/core/double_to_fixed_convert_assert.svh =====
// Assertion macros for the double to fixed-point converter.
// Used by the top level only; no other dependencies.
`ifndef DOUBLE_TO_FIXED_CONVERT_ASSERT_SVH
`define DOUBLE_TO_FIXED_CONVERT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define DFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define DFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/dfc_pkg.sv =====
// Package for the double to fixed-point converter: constants and stage types.
// No dependencies.
`default_nettype none
package dfc_pkg;
    localparam int OutWidthDefault = 64;
    localparam int ExpBias = 1023;
    localparam int MantBits = 52;
    localparam logic [0:0] RegFracBits = 1'b0;
    localparam logic [0:0] RegIntBits = 1'b1;

    // Decoded operand carried from the first to the second stage.
    typedef struct packed {
        logic        neg;
        logic        is_special;
        logic        is_zero;
        logic [52:0] sig;
        logic        left;
        logic [12:0] shift;
        logic [6:0]  lead_pos;
        logic [5:0]  width;
    } dfc_dec_t;
endpackage
`default_nettype wire

// ===== rtl/core/dfc_decode.sv =====
// Stage one: splits the double, restores the hidden one and works out the shift.
// Depends on dfc_pkg.
`default_nettype none
module dfc_decode #(
    parameter int OUT_WIDTH = 64
) (
    input  wire logic [63:0]       float_bits,
    input  wire logic [5:0]        frac_bits,
    input  wire logic [5:0]        int_bits,
    output dfc_pkg::dfc_dec_t      dec
);
    import dfc_pkg::*;

    logic [10:0] expf;
    logic [6:0]  wsum;
    logic [6:0]  wlim;
    logic signed [13:0] s;

    assign expf = float_bits[62:52];
    assign wsum = {1'b0, frac_bits} + {1'b0, int_bits};
    assign s = $signed({3'b000, expf}) - 14'sd1075 + $signed({8'b0, frac_bits});

    always_comb
    begin
        wlim = wsum;
        if (wlim > 7'd63)
        begin
            wlim = 7'd63;
        end
        if (wlim > 7'(OUT_WIDTH - 1))
        begin
            wlim = 7'(OUT_WIDTH - 1);
        end
        dec.neg = float_bits[63];
        dec.is_special = (expf == 11'h7FF);
        dec.is_zero = (expf == 11'd0);
        dec.sig = {1'b1, float_bits[51:0]};
        dec.left = !s[13];
        dec.shift = s[13] ? 13'(-s) : s[12:0];
        dec.width = wlim[5:0];
        // Leading one lands at bit 52 + s; only needed when s is small.
        dec.lead_pos = (!s[13] && s < 14'sd64) ? 7'(s + 14'sd52) : 7'd127;
    end
endmodule
`default_nettype wire

// ===== rtl/core/dfc_shift.sv =====
// Stage two: shifts the significand and decides saturation.
// Depends on dfc_pkg.
`default_nettype none
module dfc_shift (
    input  dfc_pkg::dfc_dec_t   dec,
    output logic                neg,
    output logic [62:0]         mag,
    output logic                ovf
);
    import dfc_pkg::*;

    logic [62:0] maxmag;
    logic [62:0] shifted;

    always_comb
    begin
        maxmag = 63'((64'd1 << dec.width) - 64'd1);
        shifted = '0;
        ovf = 1'b0;
        if (dec.is_special)
        begin
            ovf = 1'b1;
        end
        else if (!dec.is_zero)
        begin
            if (dec.left)
            begin
                if (dec.lead_pos >= {1'b0, dec.width})
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    // The leading one stays below the width here, so the shift is small.
                    shifted = {10'b0, dec.sig} << dec.shift[5:0];
                end
            end
            else if (dec.shift <= 13'd52)
            begin
                shifted = {10'b0, dec.sig >> dec.shift[5:0]};
                ovf = (shifted > maxmag);
            end
        end
        mag = ovf ? maxmag : shifted;
        neg = dec.neg;
    end
endmodule
`default_nettype wire

// ===== rtl/core/double_to_fixed_convert.sv =====
// Double to signed fixed-point converter, three-stage pipeline top level.
// Depends on dfc_pkg, dfc_decode, dfc_shift and the assertion header.
//
// Usage: the input channel (in_valid/in_ready) carries one double per beat;
// the output channel (out_valid/out_ready) returns fixed_value and overflow.
// A beat crosses three register stages before out_valid; throughput is one
// beat per cycle while out_ready stays high. Stage one decodes, stage
// two shifts and saturates, stage three negates into the output register.
// Every stage advances when the one after it is empty or being emptied, so a
// stalled receiver holds every beat in place and none is lost or repeated.
// Reset clears all valid bits and
// sets frac_bits to 32 and int_bits to 31. Configuration writes through
// cfg_we/cfg_index/cfg_data take effect at once; the user must make them only
// while the pipeline is empty, as the block itself does not enforce this.
`default_nettype none
`include "double_to_fixed_convert_assert.svh"
module double_to_fixed_convert #(
    parameter int OUT_WIDTH = dfc_pkg::OutWidthDefault
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [63:0]           float_bits,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [63:0]         fixed_value,
    output logic                       overflow,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [5:0]            cfg_data
);
    import dfc_pkg::*;

    logic [5:0] frac_reg;
    logic [5:0] int_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;
    dfc_dec_t dec, dec_reg;
    logic neg_c, ovf_c;
    logic [62:0] mag_c;
    logic neg_reg, ovf2_reg;
    logic [62:0] mag_reg;
    logic signed [63:0] fixed_reg;
    logic ovf_reg;

    dfc_decode #(.OUT_WIDTH(OUT_WIDTH)) u_dec (
        .float_bits(float_bits), .frac_bits(frac_reg), .int_bits(int_reg), .dec(dec)
    );
    dfc_shift u_shift (.dec(dec_reg), .neg(neg_c), .mag(mag_c), .ovf(ovf_c));

    assign adv3 = !v3_reg || out_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= 6'd32;
            int_reg <= 6'd31;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    RegFracBits: frac_reg <= cfg_data;
                    RegIntBits:  int_reg <= cfg_data;
                    default:     frac_reg <= frac_reg;
                endcase
            end
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid) dec_reg <= dec;
        if (adv2 && v1_reg)
        begin
            neg_reg <= neg_c;
            mag_reg <= mag_c;
            ovf2_reg <= ovf_c;
        end
        if (adv3 && v2_reg)
        begin
            fixed_reg <= neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
            ovf_reg <= ovf2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign fixed_value = fixed_reg;
    assign overflow = ovf_reg;

    `DFC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(fixed_value))
    `DFC_ASSERT_IMP(a_ready, !out_valid, in_ready)
    `DFC_ASSERT_NEXT(a_adv, v2_reg && adv3, out_valid)
endmodule
`default_nettype wire
